// File: design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: label");

`endif

// File: design/lltill_pkg.sv
package lltill_pkg;

    localparam int MAX_TILLS = 16;
    localparam int CFG_W     = 5;
    localparam int TIME_W    = 16;
    localparam int LOAD_W    = 32;
    localparam int CODE_W    = 4;
    localparam int IDX_W     = (MAX_TILLS > 1) ? $clog2(MAX_TILLS) : 1;
    localparam int CNT_W     = $clog2(MAX_TILLS + 1);
    localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef logic [LOAD_W-1:0] t_load;

    typedef struct packed {
        logic start;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

    function automatic logic [CODE_W-1:0] till_code(input logic [IDX_W-1:0] idx);
        logic [IDX_W+CODE_W-1:0] wide;
        wide = {{CODE_W{1'b0}}, idx};
        return wide[CODE_W-1:0];
    endfunction

endpackage

// File: design/lltill_ctrl.sv
`include "assert_macros.svh"

module lltill_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  lltill_pkg::t_sts  i_sts,
    output lltill_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_s_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd.start  = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = ST_UPDATE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_UPDATE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_CLK(a_commit_needs_room, i_clk, i_rst_n, o_cmd.commit |-> i_sts.out_free)
    `ASSERT_CLK(a_update_waits, i_clk, i_rst_n,
        (r_state == ST_UPDATE && !i_sts.out_free) |=> (r_state == ST_UPDATE))
    `ASSERT_CLK(a_start_to_scan, i_clk, i_rst_n, o_cmd.start |=> (r_state == ST_SCAN))

endmodule

// File: design/lltill_datapath.sv
`include "assert_macros.svh"

module lltill_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic [lltill_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic [lltill_pkg::TIME_W-1:0]          i_time,
    input  logic                                   i_last,
    input  logic                                   i_out_ready,
    input  lltill_pkg::t_cmd                       i_cmd,
    output lltill_pkg::t_sts                       o_sts,
    output logic                                   o_out_valid,
    output logic [lltill_pkg::CODE_W-1:0]          o_out_till,
    output lltill_pkg::t_load                      o_out_finish,
    output lltill_pkg::t_load                      o_out_span,
    output logic                                   o_out_last
);

    lltill_pkg::t_load                 r_load [lltill_pkg::MAX_TILLS];
    lltill_pkg::t_load                 r_max;
    logic [lltill_pkg::CFG_W-1:0]      r_active;
    logic [lltill_pkg::CNT_W-1:0]      r_j;
    logic [lltill_pkg::IDX_W-1:0]      r_best;
    lltill_pkg::t_load                 r_best_val;
    logic [lltill_pkg::TIME_W-1:0]     r_time;
    logic                              r_last;
    logic                              r_out_valid;
    logic [lltill_pkg::CODE_W-1:0]     r_out_till;
    lltill_pkg::t_load                 r_out_finish;
    lltill_pkg::t_load                 r_out_span;
    logic                              r_out_last;

    logic [lltill_pkg::CMP_W-1:0]      act_w;
    logic [lltill_pkg::CNT_W-1:0]      k_eff;
    lltill_pkg::t_load                 scan_val;
    logic [lltill_pkg::LOAD_W:0]       sum;
    lltill_pkg::t_load                 n_finish;
    lltill_pkg::t_load                 n_span;

    always_comb begin
        act_w = lltill_pkg::CMP_W'(r_active);
        priority if (act_w == '0) begin
            k_eff = lltill_pkg::CNT_W'(1);
        end else if (act_w > lltill_pkg::CMP_W'(lltill_pkg::MAX_TILLS)) begin
            k_eff = lltill_pkg::CNT_W'(lltill_pkg::MAX_TILLS);
        end else begin
            k_eff = act_w[lltill_pkg::CNT_W-1:0];
        end
    end

    assign scan_val = r_load[r_j[lltill_pkg::IDX_W-1:0]];
    assign sum      = {1'b0, r_best_val} + {{(lltill_pkg::LOAD_W + 1 - lltill_pkg::TIME_W){1'b0}},
                                            r_time};
    assign n_finish = sum[lltill_pkg::LOAD_W] ? '1 : sum[lltill_pkg::LOAD_W-1:0];
    assign n_span   = (n_finish > r_max) ? n_finish : r_max;

    assign o_sts.scan_done = (r_j >= k_eff);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= lltill_pkg::CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_active <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j    <= lltill_pkg::CNT_W'(1);
            r_best <= '0;
        end else if (i_cmd.start) begin
            r_j    <= lltill_pkg::CNT_W'(1);
            r_best <= '0;
        end else if (i_cmd.step) begin
            r_j <= r_j + lltill_pkg::CNT_W'(1);
            if (scan_val < r_best_val) begin
                r_best <= r_j[lltill_pkg::IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_best_val <= r_load[0];
            r_time     <= i_time;
            r_last     <= i_last;
        end else if (i_cmd.step && (scan_val < r_best_val)) begin
            r_best_val <= scan_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lltill_pkg::MAX_TILLS; i++) begin
                r_load[i] <= '0;
            end
            r_max <= '0;
        end else if (i_cmd.commit) begin
            if (r_last) begin
                for (int i = 0; i < lltill_pkg::MAX_TILLS; i++) begin
                    r_load[i] <= '0;
                end
                r_max <= '0;
            end else begin
                r_load[r_best] <= n_finish;
                r_max          <= n_span;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_till   <= lltill_pkg::till_code(r_best);
            r_out_finish <= n_finish;
            r_out_span   <= n_span;
            r_out_last   <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_till   = r_out_till;
    assign o_out_finish = r_out_finish;
    assign o_out_span   = r_out_span;
    assign o_out_last   = r_out_last;

    `ASSERT_CLK(a_finish_le_span, i_clk, i_rst_n, r_out_valid |-> (r_out_finish <= r_out_span))
    `ASSERT_CLK(a_commit_shows, i_clk, i_rst_n, i_cmd.commit |=> r_out_valid)
    `ASSERT_CLK(a_scan_bound, i_clk, i_rst_n, i_cmd.step |-> (r_j < k_eff))

endmodule

// File: design/least_loaded_till_scheduler_core.sv
// Channel   | Direction | Fields (low bit first)
// s_axis    | in        | tdata: service_time[15:0]; tlast: last_job
// m_axis    | out       | tdata: chosen_till[3:0], till_finish[35:4], makespan[67:36];
//           |           | tlast: batch_done
// cfg       | in        | data: active_tills[4:0]
// An item runs in steps, k being active_tills held to 1..16: capture and read till 0,
// scan the first k tills (a compare for each further till, then an exit), then add and
// write back.
// A new item is taken while the previous result waits in the output register.
// Write back stalls while the output register holds an untaken result.
// Reset clears all loads and the makespan at once; active_tills resets to 1.

module least_loaded_till_scheduler_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [15:0]                        s_axis_tdata,  // service_time
    input  logic                               s_axis_tlast,  // last_job
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [71:0]                        m_axis_tdata,  // chosen_till, till_finish, makespan
    output logic                               m_axis_tlast,  // batch_done
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lltill_pkg::CFG_W-1:0]       i_cfg_data     // active_tills
);

    lltill_pkg::t_cmd                  cmd;
    lltill_pkg::t_sts                  sts;
    logic [lltill_pkg::CODE_W-1:0]     out_till;
    lltill_pkg::t_load                 out_finish;
    lltill_pkg::t_load                 out_span;

    assign o_cfg_ready = 1'b1;

    lltill_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    lltill_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_time       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_out_ready  (m_axis_tready),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (m_axis_tvalid),
        .o_out_till   (out_till),
        .o_out_finish (out_finish),
        .o_out_span   (out_span),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, out_span, out_finish, out_till};

endmodule
